// ===== sv/gnt_pkg.sv =====
// Package for the gradient noise turbulence block: widths, commands, constants.
// Used by the top level and the checker; depends on nothing.
`default_nettype none
package gnt_pkg;
  localparam int IDX_W     = 8;
  localparam int TBL_DEPTH = 256;
  localparam int FRAC      = 16;
  localparam int GFRAC     = 14;
  localparam int MAX_OCT   = 8;
  localparam int GRAD_W    = 48;

  localparam logic [2:0] CMD_PERM_X = 3'd0;
  localparam logic [2:0] CMD_PERM_Y = 3'd1;
  localparam logic [2:0] CMD_PERM_Z = 3'd2;
  localparam logic [2:0] CMD_GRAD   = 3'd3;
  localparam logic [2:0] CMD_EVAL   = 3'd4;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_OCT  = 2'd1;

  localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;
endpackage
`default_nettype wire

// ===== sv/gradient_noise_turbulence.sv =====
// Top level of the gradient noise turbulence block: tables, sequencer, datapath.
// Depends on gnt_pkg and gnt_ram.
//
// A load word writes one entry of a permutation table or of the gradient table
// in the cycle it is taken. An evaluate word runs the smoothstep set-up, u*u
// and then t*(3-2u), per octave. Then come 8 lattice corners, each in turn: the
// permutation RAM reads, the gradient RAM read addressed by the hashed data,
// then the dot and weight products and the accumulate. A last step folds the
// octave into the sum. Noise mode runs one octave, turbulence mode the set
// octave count, capped at 8; with a count of zero in turbulence mode no octave
// runs and the result is zero. The input is stalled while a word is evaluated.
// A finished result waits in the output register while the next word is
// taken, and a following result is held back until the waiting one has been
// handed on.
`default_nettype none
module gradient_noise_turbulence (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_cmd,
  input  wire logic [7:0]          in_table_index,
  input  wire logic [7:0]          in_perm_value,
  input  wire logic signed [15:0]  in_grad_x,
  input  wire logic signed [15:0]  in_grad_y,
  input  wire logic signed [15:0]  in_grad_z,
  input  wire logic signed [31:0]  in_pos_x,
  input  wire logic signed [31:0]  in_pos_y,
  input  wire logic signed [31:0]  in_pos_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [23:0]       out_noise_value,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import gnt_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SM0  = 4'd1;  // u*u per axis
  localparam logic [3:0] S_SM1  = 4'd2;  // t*(3-2u)
  localparam logic [3:0] S_C0   = 4'd3;  // perm reads issued
  localparam logic [3:0] S_C1   = 4'd4;  // perm data, grad read issued
  localparam logic [3:0] S_C2   = 4'd5;  // grad data, wx*wy
  localparam logic [3:0] S_C3   = 4'd6;  // dot, wt*wz
  localparam logic [3:0] S_C4   = 4'd7;  // dot*weight, accumulate
  localparam logic [3:0] S_OCT  = 4'd8;  // octave finish
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] st_r, st_nxt;

  // Configuration registers.
  logic       mode_r;
  logic [3:0] oct_cnt_r;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      oct_cnt_r <= 4'd7;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'({REG_MODE, 2'b00})) begin
        mode_r <= pwdata[0];
      end else if (paddr == 3'({REG_OCT, 2'b00})) begin
        oct_cnt_r <= pwdata[3:0];
      end
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr == 3'({REG_MODE, 2'b00})) prdata = {31'd0, mode_r};
    else if (paddr == 3'({REG_OCT, 2'b00})) prdata = {28'd0, oct_cnt_r};
  end

  // Input acceptance; a finished result is held back while the last one waits.
  logic acc_in;
  logic out_hold;
  assign in_stall = (st_r != S_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;

  // Captured point and progress counters.
  logic [31:0] px_r, py_r, pz_r;
  logic [3:0]  oct_r;
  logic [3:0]  n_oct_r;
  logic [2:0]  cor_r;
  logic [31:0] sx, sy, sz;
  assign sx = px_r << oct_r;
  assign sy = py_r << oct_r;
  assign sz = pz_r << oct_r;

  // Tables.
  logic [IDX_W-1:0] ix, iy, iz, gaddr;
  logic [7:0] rpx, rpy, rpz;
  logic [GRAD_W-1:0] rg;
  logic acc_px, acc_py, acc_pz, acc_g;
  assign acc_px = acc_in && in_cmd == CMD_PERM_X;
  assign acc_py = acc_in && in_cmd == CMD_PERM_Y;
  assign acc_pz = acc_in && in_cmd == CMD_PERM_Z;
  assign acc_g  = acc_in && in_cmd == CMD_GRAD;
  assign ix = sx[FRAC +: IDX_W] + {7'd0, cor_r[2]};
  assign iy = sy[FRAC +: IDX_W] + {7'd0, cor_r[1]};
  assign iz = sz[FRAC +: IDX_W] + {7'd0, cor_r[0]};
  assign gaddr = rpx ^ rpy ^ rpz;

  gnt_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_px (.clk(clk), .we(acc_px),
    .waddr(in_table_index), .wdata(in_perm_value), .raddr(ix), .rdata(rpx));
  gnt_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_py (.clk(clk), .we(acc_py),
    .waddr(in_table_index), .wdata(in_perm_value), .raddr(iy), .rdata(rpy));
  gnt_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_pz (.clk(clk), .we(acc_pz),
    .waddr(in_table_index), .wdata(in_perm_value), .raddr(iz), .rdata(rpz));
  gnt_ram #(.WIDTH(GRAD_W), .DEPTH(TBL_DEPTH)) u_gr (.clk(clk), .we(acc_g),
    .waddr(in_table_index), .wdata({in_grad_z, in_grad_y, in_grad_x}),
    .raddr(gaddr), .rdata(rg));

  // Smoothstep per axis (fractions are 16 bits, products fit 34 bits).
  logic [15:0] ux, uy, uz;
  assign ux = sx[15:0];
  assign uy = sy[15:0];
  assign uz = sz[15:0];
  logic [15:0] tx_r, ty_r, tz_r;
  logic [16:0] smx_r, smy_r, smz_r;
  logic [33:0] smx_p, smy_p, smz_p;
  assign smx_p = {18'd0, tx_r} * (18'h30000 - {1'b0, ux, 1'b0});
  assign smy_p = {18'd0, ty_r} * (18'h30000 - {1'b0, uy, 1'b0});
  assign smz_p = {18'd0, tz_r} * (18'h30000 - {1'b0, uz, 1'b0});

  // Per-corner weights and offsets.
  logic [16:0] wx, wy, wz;
  assign wx = cor_r[2] ? smx_r : 17'h10000 - smx_r;
  assign wy = cor_r[1] ? smy_r : 17'h10000 - smy_r;
  assign wz = cor_r[0] ? smz_r : 17'h10000 - smz_r;
  logic signed [17:0] ox, oy, oz;
  assign ox = $signed({2'b00, ux}) - (cor_r[2] ? 18'sh10000 : 18'sh0);
  assign oy = $signed({2'b00, uy}) - (cor_r[1] ? 18'sh10000 : 18'sh0);
  assign oz = $signed({2'b00, uz}) - (cor_r[0] ? 18'sh10000 : 18'sh0);

  logic [16:0] wxy_r, wt_r;
  logic signed [35:0] dot_r;
  logic signed [35:0] dot_full;
  assign dot_full = 36'($signed(rg[15:0]) * ox) + 36'($signed(rg[31:16]) * oy)
                  + 36'($signed(rg[47:32]) * oz);
  logic [33:0] wxy_p, wt_p;
  assign wxy_p = {17'd0, wx} * {17'd0, wy};
  assign wt_p  = {17'd0, wxy_r} * {17'd0, wz};
  logic signed [21:0] dsh;
  assign dsh = 22'(dot_r >>> GFRAC);
  logic signed [39:0] contrib;
  assign contrib = 40'((dsh * $signed({1'b0, wt_r})) >>> FRAC);

  // The octave sum is complete once the last octave has been folded in.
  logic signed [39:0] noise_r, sum_r;
  logic signed [39:0] tot, mag;
  assign tot = sum_r + (noise_r >>> oct_r);
  assign mag = mode_r ? (sum_r < 0 ? -sum_r : sum_r) : noise_r;

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (acc_in && in_cmd == CMD_EVAL)
                st_nxt = (mode_r && oct_cnt_r == 4'd0) ? S_DONE : S_SM0;
      S_SM0:  st_nxt = S_SM1;
      S_SM1:  st_nxt = S_C0;
      S_C0:   st_nxt = S_C1;
      S_C1:   st_nxt = S_C2;
      S_C2:   st_nxt = S_C3;
      S_C3:   st_nxt = S_C4;
      S_C4:   st_nxt = (cor_r == 3'd7) ? S_OCT : S_C0;
      S_OCT:  st_nxt = (!mode_r || oct_r + 4'd1 == n_oct_r) ? S_DONE : S_SM0;
      S_DONE: st_nxt = out_hold ? S_DONE : S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (st_r == S_DONE && !out_hold) out_valid <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
        oct_r <= 4'd0; cor_r <= 3'd0; sum_r <= '0; noise_r <= '0;
        n_oct_r <= (oct_cnt_r > 4'(MAX_OCT)) ? 4'(MAX_OCT) : oct_cnt_r;
      end
      S_SM0: begin
        tx_r <= 16'(({16'd0, ux} * {16'd0, ux}) >> FRAC);
        ty_r <= 16'(({16'd0, uy} * {16'd0, uy}) >> FRAC);
        tz_r <= 16'(({16'd0, uz} * {16'd0, uz}) >> FRAC);
        noise_r <= '0;
      end
      S_SM1: begin
        smx_r <= 17'(smx_p >> FRAC);
        smy_r <= 17'(smy_p >> FRAC);
        smz_r <= 17'(smz_p >> FRAC);
      end
      S_C2: wxy_r <= 17'(wxy_p >> FRAC);
      S_C3: begin
        dot_r <= dot_full;
        wt_r  <= 17'(wt_p >> FRAC);
      end
      S_C4: begin
        noise_r <= noise_r + contrib;
        cor_r   <= cor_r + 3'd1;
      end
      S_OCT: begin
        sum_r <= tot;
        oct_r <= oct_r + 4'd1;
      end
      S_DONE: begin
        if (!out_hold) begin
          if (mode_r && n_oct_r == 4'd0) out_noise_value <= '0;
          else if (mag > 40'(OUT_MAX)) out_noise_value <= OUT_MAX;
          else if (mag < 40'(OUT_MIN)) out_noise_value <= OUT_MIN;
          else out_noise_value <= mag[23:0];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/gnt_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module gnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/gnt_checker.sv =====
// Port-level checks for the gradient noise turbulence block, and its bind.
// Depends on gnt_pkg and gradient_noise_turbulence.
`default_nettype none
module gnt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_noise_value,
  input wire logic        pready
);
  import gnt_pkg::*;

  // A waiting result holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("result changed while stalled");
  // An accepted evaluate word keeps the input stalled on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_EVAL |=> in_stall)
    else $error("input taken during an evaluation");
  // A result appears only after the block was busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)) else $error("result from nowhere");
  // The configuration port never waits.
  assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind gradient_noise_turbulence gnt_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .out_valid(out_valid),
  .out_stall(out_stall), .out_noise_value(out_noise_value), .pready(pready));
`default_nettype wire
